// ===== rtl/indexed_sequence_store_assert.svh =====
// ----------------------------------------------------------------------------
// Indexed sequence store assertion macros
// Shorthands for clocked assertions that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication.
`define ISS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/iss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Beat types, operation and status codes, and the control word for the cells.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_ADD_HEAD  = 3'd1;
	localparam logic [2:0] OP_ADD_TAIL  = 3'd2;
	localparam logic [2:0] OP_ADD_INDEX = 3'd3;
	localparam logic [2:0] OP_DELETE    = 3'd4;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic signed [31:0] WORD_NONE = 32'shFFFF_FFFF;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [7:0]  position;
		logic signed [31:0] word_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_word;
		logic [1:0]         status;
		logic [6:0]         length;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_ctrl_t;

endpackage

// ===== rtl/iss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store cell
// Holds one word of the sequence and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module iss_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic                    clk,
	input  iss_pkg::cell_ctrl_t     ctrl,
	input  logic [PW-1:0]           pos,
	input  logic signed [31:0]      word_in,
	input  logic signed [31:0]      left_word,
	input  logic signed [31:0]      right_word,
	output logic signed [31:0]      word,
	output logic signed [31:0]      rd_word_s1
);
	import iss_pkg::*;

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic signed [31:0] word_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == pos) begin
				word_q <= word_in;
			end else if (MY_IDX > pos) begin
				word_q <= left_word;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= pos) begin
				word_q <= right_word;
			end
		end
		rd_word_s1 <= (ctrl.rd && (MY_IDX == pos)) ? word_q : '0;
	end

	assign word = word_q;

endmodule

// ===== rtl/indexed_sequence_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store
// Ordered store of up to CAPACITY signed words with read, insert and delete.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high; busy stays low,
// so one request can be issued every cycle. Its result appears on rsp for
// exactly one cycle, flagged by done, in the cycle right after acceptance,
// and must be captured then since it cannot be held off. The words live in a
// row of CAPACITY cells; an insert or a delete moves every later word one
// cell along on the same edge; a read registers the selected cell's word and
// merges the cell outputs by an OR tree. The length field shows the word count
// masked to seven bits. Positions at or past the length are never read back.
module indexed_sequence_store #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  iss_pkg::req_t req,
	output logic          done,
	output iss_pkg::rsp_t rsp
);
	import iss_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > 7) ? CW : 7;

	logic                  accept;
	logic                  pos_neg;
	logic [EW-1:0]         pos_u;
	logic [EW-1:0]         count_e;
	logic                  full;
	logic [CW-1:0]         count_q;
	cell_ctrl_t            ctrl;
	logic [EW-1:0]         cell_pos;
	logic [1:0]            status_c;
	logic                  v_s1;
	logic                  rd_ok_s1;
	logic [1:0]            status_s1;
	logic signed [31:0]    words [CAPACITY];
	logic signed [31:0]    rd_words [CAPACITY];
	logic signed [31:0]    rd_any;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign pos_neg = req.position[7];
	assign pos_u   = EW'(req.position[6:0]);
	assign count_e = EW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));

	always_comb begin
		ctrl     = '0;
		cell_pos = '0;
		status_c = ST_DONE;
		case (req.func)
			OP_READ: begin
				if (pos_neg || pos_u >= count_e) begin
					status_c = ST_BADPOS;
				end else begin
					ctrl.rd  = 1'b1;
					cell_pos = pos_u;
				end
			end
			OP_ADD_HEAD: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
				end
			end
			OP_ADD_TAIL: begin
				if (full) begin
					status_c = ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
					cell_pos = count_e;
				end
			end
			OP_ADD_INDEX: begin
				if (!pos_neg && pos_u > count_e) begin
					status_c = ST_BADPOS;
				end else if (full) begin
					status_c = ST_FULL;
				end else begin
					ctrl.ins = 1'b1;
					cell_pos = pos_neg ? '0 : pos_u;
				end
			end
			OP_DELETE: begin
				if (pos_neg || pos_u >= count_e) begin
					status_c = ST_BADPOS;
				end else begin
					ctrl.del = 1'b1;
					cell_pos = pos_u;
				end
			end
			default: begin
				status_c = ST_BADPOS;
			end
		endcase
		if (!accept) begin
			ctrl = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_w;
		logic signed [31:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		iss_cell #(
			.IDX(i),
			.PW (EW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.pos       (cell_pos),
			.word_in   (req.word_in),
			.left_word (left_w),
			.right_word(right_w),
			.word      (words[i]),
			.rd_word_s1(rd_words[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.del) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			rd_ok_s1  <= ctrl.rd;
		end
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_any = rd_any | rd_words[i];
		end
	end

	assign done          = v_s1;
	assign rsp.read_word = rd_ok_s1 ? rd_any : WORD_NONE;
	assign rsp.status    = status_s1;
	assign rsp.length    = count_e[6:0];

endmodule

// ===== rtl/iss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store checker
// Port-level checks on result timing, status and reported length.
// ----------------------------------------------------------------------------
`include "indexed_sequence_store_assert.svh"

module iss_checker #(
	parameter int CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input iss_pkg::rsp_t rsp
);
	import iss_pkg::*;

	`ISS_ASSERT_NXT(a_done_after_beat, start && !busy, done, "Missing result beat.")
	`ISS_ASSERT_NXT(a_no_extra_done, !(start && !busy), !done, "Unrequested result beat.")
	`ISS_ASSERT_IMP(a_refused_keeps_length, done && rsp.status != ST_DONE,
		rsp.length == $past(rsp.length), "Length changed on a refused request.")
	`ISS_ASSERT_IMP(a_full_length, done && rsp.status == ST_FULL,
		rsp.length == 7'(CAPACITY), "Full status with a store that is not full.")

endmodule

bind indexed_sequence_store iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (.*);
